/* rtl/berq_pkg.sv */
// Shared types, field widths, codes and repeat-timer helpers for the button qualifier.
package berq_pkg;

  localparam int RAW_W       = 22;
  localparam int PAD_IDX_W   = 2;
  localparam int STICK_W     = 8;
  localparam int ELAPSED_W   = 10;
  localparam int RIDX_W      = 5;
  localparam int THR_W       = 7;
  localparam int PERIOD_W    = 10;
  localparam int OUT_TIME_W  = 20;

  localparam int IN_DATA_W   = 56;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 112;
  localparam int OUT_USED_W  = 3 * RAW_W + 2 * OUT_TIME_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  // Direction bits inside the button word
  localparam int DIR_UP_BIT    = 4;
  localparam int DIR_RIGHT_BIT = 5;
  localparam int DIR_DOWN_BIT  = 6;
  localparam int DIR_LEFT_BIT  = 7;

  localparam logic [THR_W-1:0]    THRESHOLD_RESET = THR_W'(50);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(350);

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIGITAL_MODE  = 2'd0,
    REG_STICK_PRESENT = 2'd1,
    REG_THRESHOLD     = 2'd2,
    REG_PERIOD        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                digital_stick_mode;
    logic                stick_present;
    logic [THR_W-1:0]    stick_threshold;
    logic [PERIOD_W-1:0] repeat_period_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [PAD_IDX_W-1:0]       pad_index;
    logic                       poll_ok;
    logic [RAW_W-1:0]           buttons_raw;
    logic signed [STICK_W-1:0]  stick_x;
    logic signed [STICK_W-1:0]  stick_y;
    logic [ELAPSED_W-1:0]       elapsed_ms;
    logic [RIDX_W-1:0]          read_index;
  } item_t;

  // State write strobes from the update logic
  typedef struct packed {
    logic pad_wr;
    logic row_wr;
  } wr_ctl_t;

  typedef struct packed {
    logic                fire;
    logic [PERIOD_W-1:0] value;
  } countdown_t;

  function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] t,
                                                       input logic [PERIOD_W-1:0] period);
    return (t > period) ? period : t;
  endfunction

  // Fire and reload once the remaining time is used up, else count down
  function automatic countdown_t count_down(input logic [PERIOD_W-1:0]  t,
                                            input logic [ELAPSED_W-1:0] elapsed,
                                            input logic [PERIOD_W-1:0]  period);
    countdown_t r;
    if (t <= elapsed) begin
      r.fire  = 1'b1;
      r.value = period;
    end else begin
      r.fire  = 1'b0;
      r.value = t - elapsed;
    end
    return r;
  endfunction

endpackage

/* rtl/berq_core.sv */
// Update and read logic for one registered item: edges, stick directions, timers.
module berq_core #(
  parameter int BUTTONS   = 22,
  parameter int TIME_BITS = 20
) (
  input  berq_pkg::cfg_t                          cfg,
  input  berq_pkg::item_t                         item,
  input  logic                                    pad_valid,
  input  logic [BUTTONS-1:0]                      level,
  input  logic [berq_pkg::PERIOD_W-1:0]           stick_t,
  input  logic [berq_pkg::PERIOD_W-1:0]           dir_t,
  input  logic [BUTTONS-1:0][TIME_BITS-1:0]       held_row,
  input  logic [BUTTONS-1:0][TIME_BITS-1:0]       idle_row,
  output berq_pkg::wr_ctl_t                       wr,
  output logic [BUTTONS-1:0]                      level_next,
  output logic [berq_pkg::PERIOD_W-1:0]           stick_t_next,
  output logic [berq_pkg::PERIOD_W-1:0]           dir_t_next,
  output logic [BUTTONS-1:0][TIME_BITS-1:0]       held_row_next,
  output logic [BUTTONS-1:0][TIME_BITS-1:0]       idle_row_next,
  output logic [berq_pkg::RAW_W-1:0]              buttons_on,
  output logic [berq_pkg::RAW_W-1:0]              buttons_pressed,
  output logic [berq_pkg::RAW_W-1:0]              buttons_released,
  output logic [berq_pkg::OUT_TIME_W-1:0]         held_time_ms,
  output logic [berq_pkg::OUT_TIME_W-1:0]         idle_time_ms
);
  import berq_pkg::*;

  localparam int BIDX_W = $clog2(BUTTONS);

  logic [PERIOD_W-1:0]     st_clamped;
  logic [PERIOD_W-1:0]     dt_clamped;
  logic [BUTTONS-1:0]      raw;
  logic [BUTTONS-1:0]      fake;
  logic [BUTTONS-1:0]      new_on;
  logic [BUTTONS-1:0]      pressed;
  logic [BUTTONS-1:0]      released;
  logic signed [STICK_W:0] sx;
  logic signed [STICK_W:0] sy;
  logic signed [STICK_W:0] thr;
  logic signed [STICK_W:0] thr_neg;
  countdown_t              st_cd;
  countdown_t              dt_cd;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                   input logic [ELAPSED_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = (TIME_BITS+1)'(t) + (TIME_BITS+1)'(d);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  assign st_clamped = clamp_period(stick_t, cfg.repeat_period_ms);
  assign dt_clamped = clamp_period(dir_t, cfg.repeat_period_ms);
  assign raw        = BUTTONS'(item.buttons_raw);
  assign sx         = {item.stick_x[STICK_W-1], item.stick_x};
  assign sy         = {item.stick_y[STICK_W-1], item.stick_y};
  assign thr        = $signed({2'b00, cfg.stick_threshold});
  assign thr_neg    = -thr;
  assign st_cd      = count_down(st_clamped, item.elapsed_ms, cfg.repeat_period_ms);
  assign dt_cd      = count_down(dt_clamped, item.elapsed_ms, cfg.repeat_period_ms);

  always_comb begin
    fake = '0;
    if (sx >= thr) begin
      fake[DIR_RIGHT_BIT] = 1'b1;
    end else if (sx <= thr_neg) begin
      fake[DIR_LEFT_BIT] = 1'b1;
    end
    if (sy >= thr) begin
      fake[DIR_DOWN_BIT] = 1'b1;
    end else if (sy <= thr_neg) begin
      fake[DIR_UP_BIT] = 1'b1;
    end
  end

  always_comb begin
    wr               = '0;
    level_next       = level;
    stick_t_next     = stick_t;
    dir_t_next       = dir_t;
    held_row_next    = held_row;
    idle_row_next    = idle_row;
    new_on           = level;
    pressed          = '0;
    released         = '0;
    buttons_on       = '0;
    buttons_pressed  = '0;
    buttons_released = '0;
    held_time_ms     = '0;
    idle_time_ms     = '0;

    if (pad_valid) begin
      buttons_on = RAW_W'(level);
      if (item.cmd == CMD_READ) begin
        if (int'(item.read_index) < BUTTONS) begin
          held_time_ms = OUT_TIME_W'(held_row[BIDX_W'(item.read_index)]);
          idle_time_ms = OUT_TIME_W'(idle_row[BIDX_W'(item.read_index)]);
        end
      end else begin
        wr.pad_wr    = 1'b1;
        stick_t_next = st_clamped;
        dir_t_next   = dt_clamped;
        if (item.poll_ok) begin
          wr.row_wr = 1'b1;
          new_on    = raw;
          if (cfg.digital_stick_mode && cfg.stick_present) begin
            if (fake == '0) begin
              stick_t_next = '0;
            end else begin
              stick_t_next = st_cd.value;
              if (st_cd.fire) begin
                new_on = raw | fake;
              end
            end
          end
          pressed    = new_on & ~level;
          released   = level & ~new_on;
          level_next = new_on;

          for (int b = 0; b < BUTTONS; b++) begin
            if (pressed[b]) begin
              held_row_next[b] = '0;
            end else if (released[b]) begin
              idle_row_next[b] = '0;
            end
            if (new_on[b]) begin
              held_row_next[b] = sat_add(held_row_next[b], item.elapsed_ms);
            end else begin
              idle_row_next[b] = sat_add(idle_row_next[b], item.elapsed_ms);
            end
          end

          // Re-fire held directions: up wins over down, left wins over right
          if (cfg.digital_stick_mode) begin
            if (new_on[DIR_LEFT_BIT:DIR_UP_BIT] == '0) begin
              dir_t_next = '0;
            end else begin
              dir_t_next = dt_cd.value;
              if (dt_cd.fire) begin
                if (new_on[DIR_UP_BIT]) begin
                  pressed[DIR_UP_BIT] = 1'b1;
                end else if (new_on[DIR_DOWN_BIT]) begin
                  pressed[DIR_DOWN_BIT] = 1'b1;
                end
                if (new_on[DIR_LEFT_BIT]) begin
                  pressed[DIR_LEFT_BIT] = 1'b1;
                end else if (new_on[DIR_RIGHT_BIT]) begin
                  pressed[DIR_RIGHT_BIT] = 1'b1;
                end
              end
            end
          end

          buttons_on       = RAW_W'(new_on);
          buttons_pressed  = RAW_W'(pressed);
          buttons_released = RAW_W'(released);
        end
      end
    end
  end

endmodule

/* rtl/button_edge_repeat_qualifier.sv */
// Button edge detector with held/idle timers and direction autorepeat, top level.
//
// Requests enter on the s_axis channel: tuser carries the command (update a pad or
// read one button's timers), tdata the pad, poll flag, raw buttons, stick, elapsed
// time and read index. Each request gives exactly one result on m_axis: qualified
// levels, press and release edges and, for reads, the two timers of one button.
// Registers are set through the cfg_we / cfg_index / cfg_data write port.
//
// Results are registered. One request is taken every cycle unless the receiver
// stalls. The per-pad timer rows sit in a memory with a registered read port; a
// row written by the previous request is forwarded to the next one.
//
// Reset clears all levels and repeat timers and restores the register defaults; the
// timer rows are cleared by one valid bit per pad, so no clearing pass follows reset.
// When the receiver stalls, the result is held in the output register and one more
// request is taken into the input stage; tready then drops until the result leaves.
module button_edge_repeat_qualifier #(
  parameter int PADS      = 4,
  parameter int BUTTONS   = 22,
  parameter int TIME_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pad_index, poll_ok, buttons_raw, stick_x, stick_y, elapsed_ms, read_index
  input  logic [berq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic [berq_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // buttons_on, buttons_pressed, buttons_released, held_time_ms, idle_time_ms
  output logic [berq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [berq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [berq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import berq_pkg::*;

  localparam int PAD_W = (PADS > 1) ? $clog2(PADS) : 1;

  typedef logic [BUTTONS-1:0][TIME_BITS-1:0] row_t;

  cfg_t                cfg;
  item_t               in_item;
  item_t               s1_item;
  logic                s1_valid;
  logic                accept;
  logic                advance;
  logic [PAD_W-1:0]    in_pad;
  logic [PAD_W-1:0]    s1_pad;
  logic                s1_pad_ok;

  logic [BUTTONS-1:0]  level_q [PADS];
  logic [PERIOD_W-1:0] stick_t_q [PADS];
  logic [PERIOD_W-1:0] dir_t_q [PADS];

  row_t                held_mem [PADS];
  row_t                idle_mem [PADS];
  logic [PADS-1:0]     row_valid;
  row_t                rd_held;
  row_t                rd_idle;
  logic                rd_valid;
  row_t                fwd_held;
  row_t                fwd_idle;
  logic                fwd_hit;
  row_t                cur_held;
  row_t                cur_idle;

  wr_ctl_t             wr;
  logic                row_wr_en;
  logic                pad_wr_en;
  logic [BUTTONS-1:0]  level_next;
  logic [PERIOD_W-1:0] stick_t_next;
  logic [PERIOD_W-1:0] dir_t_next;
  row_t                held_row_next;
  row_t                idle_row_next;
  logic [RAW_W-1:0]    buttons_on;
  logic [RAW_W-1:0]    buttons_pressed;
  logic [RAW_W-1:0]    buttons_released;
  logic [OUT_TIME_W-1:0] held_time_ms;
  logic [OUT_TIME_W-1:0] idle_time_ms;

  // Request unpacking
  assign in_item.cmd         = cmd_t'(s_axis_tuser[0]);
  assign in_item.pad_index   = s_axis_tdata[1:0];
  assign in_item.poll_ok     = s_axis_tdata[2];
  assign in_item.buttons_raw = s_axis_tdata[24:3];
  assign in_item.stick_x     = s_axis_tdata[32:25];
  assign in_item.stick_y     = s_axis_tdata[40:33];
  assign in_item.elapsed_ms  = s_axis_tdata[50:41];
  assign in_item.read_index  = s_axis_tdata[55:51];

  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_pad    = PAD_W'(in_item.pad_index);
  assign s1_pad    = PAD_W'(s1_item.pad_index);
  assign s1_pad_ok = int'(s1_item.pad_index) < PADS;

  assign row_wr_en = advance && wr.row_wr;
  assign pad_wr_en = advance && wr.pad_wr;

  // Take the row just written when the memory read came too early to see it
  assign cur_held = fwd_hit ? fwd_held : (rd_valid ? rd_held : '0);
  assign cur_idle = fwd_hit ? fwd_idle : (rd_valid ? rd_idle : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.digital_stick_mode <= 1'b0;
      cfg.stick_present      <= 1'b1;
      cfg.stick_threshold    <= THRESHOLD_RESET;
      cfg.repeat_period_ms   <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIGITAL_MODE:  cfg.digital_stick_mode <= cfg_data[0];
        REG_STICK_PRESENT: cfg.stick_present      <= cfg_data[0];
        REG_THRESHOLD:     cfg.stick_threshold    <= cfg_data[THR_W-1:0];
        REG_PERIOD:        cfg.repeat_period_ms   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      row_valid     <= '0;
      fwd_hit       <= 1'b0;
      for (int p = 0; p < PADS; p++) begin
        level_q[p]   <= '0;
        stick_t_q[p] <= '0;
        dir_t_q[p]   <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= row_wr_en && (s1_pad == in_pad);
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (pad_wr_en) begin
        level_q[s1_pad]   <= level_next;
        stick_t_q[s1_pad] <= stick_t_next;
        dir_t_q[s1_pad]   <= dir_t_next;
      end
      if (row_wr_en) begin
        row_valid[s1_pad] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
    if (advance) begin
      m_axis_tdata <= {(OUT_DATA_W - OUT_USED_W)'(0), idle_time_ms, held_time_ms,
                       buttons_released, buttons_pressed, buttons_on};
    end
  end

  // Timer rows, one per pad
  always_ff @(posedge clk) begin
    if (row_wr_en) begin
      held_mem[s1_pad] <= held_row_next;
      idle_mem[s1_pad] <= idle_row_next;
      fwd_held         <= held_row_next;
      fwd_idle         <= idle_row_next;
    end
    if (accept) begin
      rd_held  <= held_mem[in_pad];
      rd_idle  <= idle_mem[in_pad];
      rd_valid <= row_valid[in_pad];
    end
  end

  berq_core #(
    .BUTTONS   (BUTTONS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .cfg              (cfg),
    .item             (s1_item),
    .pad_valid        (s1_pad_ok),
    .level            (level_q[s1_pad]),
    .stick_t          (stick_t_q[s1_pad]),
    .dir_t            (dir_t_q[s1_pad]),
    .held_row         (cur_held),
    .idle_row         (cur_idle),
    .wr               (wr),
    .level_next       (level_next),
    .stick_t_next     (stick_t_next),
    .dir_t_next       (dir_t_next),
    .held_row_next    (held_row_next),
    .idle_row_next    (idle_row_next),
    .buttons_on       (buttons_on),
    .buttons_pressed  (buttons_pressed),
    .buttons_released (buttons_released),
    .held_time_ms     (held_time_ms),
    .idle_time_ms     (idle_time_ms)
  );

`ifndef SYNTHESIS
  a_ready_only_on_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input blocked without a stalled result");

  a_row_wr_only_good_update: assert property (@(posedge clk) disable iff (rst)
    row_wr_en |-> (s1_item.cmd == CMD_UPDATE && s1_item.poll_ok && s1_pad_ok))
    else $error("timer row written by a read or failed poll");

  a_row_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    row_wr_en |=> row_valid[$past(s1_pad)])
    else $error("timer row not marked valid after write");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("result lost after leaving input stage");
`endif

endmodule
